/* hdl/tpg_pkg.sv */
// Package of shared constants, codes and types for the two-priority token bucket granter.
package tpg_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int BYTE_WIDTH_DEF  = 32;

    localparam int FAIR_W     = 7;
    localparam int RND_W      = 16;
    localparam int TAG_W      = 16;
    localparam int FIELD_W    = 32;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FAIR_W-1:0] FAIR_LIMIT = FAIR_W'(100);

    localparam logic [OUTCOME_W-1:0] OUT_GRANTED   = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_QUEUED    = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_TOO_LARGE = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_FROM_Q    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_REFILL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIRNESS = 2'd1;

    typedef struct packed {
        logic              done;
        logic [FAIR_W-1:0] remainder;
    } mod_status_t;

endpackage

/* hdl/two_priority_token_bucket_granter.sv */
// Top level of the two-priority token bucket granter.
//
// The input channel carries either a byte request (operation 0) or a refill
// tick (operation 1). A request gives exactly one result: granted at once,
// queued, queue full or too large. A tick reloads the credit and serves the
// two queues in turn, giving one result per request granted from a queue;
// a tick that grants nothing gives no result. last_result marks the final
// result of each input transfer.
// A request's result is presented in the same cycle in which the block is
// ready again. A tick first works out the remainder of the random word,
// then reads and serves the queue heads one at a time through the single
// memory read port and the shared compare and subtract of the credit, and
// then hands over its last result. The block takes no new input until the
// work of the current one is done.
// Results leave through an output register, so a new input transfer is taken
// while a result waits. When the receiver stalls, a tick holds one further
// grant back and then waits.
// Reset clears the credit, the queues and the handshakes, and loads the
// register defaults; the queue memory needs no clearing.
module two_priority_token_bucket_granter
    import tpg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int BYTE_WIDTH  = BYTE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [FIELD_W-1:0]   s_byte_count,
    input  logic                 s_priority_req,
    input  logic [TAG_W-1:0]     s_request_tag,
    input  logic [RND_W-1:0]     s_random_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUTCOME_W-1:0] m_outcome,
    output logic [TAG_W-1:0]     m_grant_tag,
    output logic                 m_grant_priority,
    output logic [FIELD_W-1:0]   m_grant_bytes,
    output logic                 m_last_result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int BW = BYTE_WIDTH;
    localparam int QD = QUEUE_DEPTH;
    localparam int HW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);
    localparam int AW = $clog2(2 * QD);
    localparam logic [AW-1:0] HIGH_BASE = AW'(QD);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REQ   = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [BW-1:0]     refill_reg, refill_next;
    logic [FAIR_W-1:0] fair_reg, fair_next;
    logic [BW-1:0]     credit_reg, credit_next;
    logic [HW-1:0]     head_reg [2];
    logic [HW-1:0]     head_next [2];
    logic [CW-1:0]     count_reg [2];
    logic [CW-1:0]     count_next [2];
    logic              q_reg, q_next;
    logic              phase_reg, phase_next;

    logic [BW-1:0]     in_bytes_reg;
    logic              in_pri_reg;
    logic [TAG_W-1:0]  in_tag_reg;

    logic                 pend_valid_reg, pend_valid_next;
    logic [OUTCOME_W-1:0] pend_outcome_reg, pend_outcome_next;
    logic [TAG_W-1:0]     pend_tag_reg, pend_tag_next;
    logic                 pend_pri_reg, pend_pri_next;
    logic [BW-1:0]        pend_bytes_reg, pend_bytes_next;

    logic                 m_valid_reg, m_valid_next;
    logic [OUTCOME_W-1:0] m_outcome_reg;
    logic [TAG_W-1:0]     m_tag_reg;
    logic                 m_pri_reg;
    logic [FIELD_W-1:0]   m_bytes_reg;
    logic                 m_last_reg;
    logic                 m_load;
    logic                 m_load_last;

    logic [BW-1:0]    mem_rem  [2*QD];
    logic [BW-1:0]    mem_orig [2*QD];
    logic [TAG_W-1:0] mem_tag  [2*QD];
    logic [BW-1:0]    rd_rem_reg, rd_orig_reg;
    logic [TAG_W-1:0] rd_tag_reg;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             wr_rem_en, wr_push_en;
    logic [BW-1:0]    wr_rem_data;

    logic [HW:0]       tail_sum;
    logic [HW-1:0]     tail_idx;
    logic [FAIR_W-1:0] fair_clamped;
    logic              accept, out_free, mod_start;
    mod_status_t       mod_status;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (fair_reg == '0) begin
            fair_clamped = FAIR_W'(1);
        end else if (fair_reg > FAIR_LIMIT) begin
            fair_clamped = FAIR_LIMIT;
        end else begin
            fair_clamped = fair_reg;
        end
    end

    assign mod_start = accept && s_operation;

    tpg_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (s_random_word),
        .divisor  (fair_clamped),
        .status   (mod_status)
    );

    always_comb begin
        tail_sum = (HW+1)'(head_reg[in_pri_reg]) + (HW+1)'(count_reg[in_pri_reg]);
        if (tail_sum >= (HW+1)'(QD)) begin
            tail_sum = tail_sum - (HW+1)'(QD);
        end
        tail_idx = tail_sum[HW-1:0];
        rd_addr  = q_reg ? HIGH_BASE + AW'(head_reg[1]) : AW'(head_reg[0]);
    end

    always_comb begin
        state_next        = state_reg;
        refill_next       = refill_reg;
        fair_next         = fair_reg;
        credit_next       = credit_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        q_next            = q_reg;
        phase_next        = phase_reg;
        pend_valid_next   = pend_valid_reg;
        pend_outcome_next = pend_outcome_reg;
        pend_tag_next     = pend_tag_reg;
        pend_pri_next     = pend_pri_reg;
        pend_bytes_next   = pend_bytes_reg;
        m_load            = 1'b0;
        m_load_last       = 1'b0;
        wr_rem_en         = 1'b0;
        wr_push_en        = 1'b0;
        wr_addr           = rd_addr;
        wr_rem_data       = rd_rem_reg - credit_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_REFILL:   refill_next = BW'(cfg_data);
                CFG_FAIRNESS: fair_next   = cfg_data[FAIR_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = s_operation ? S_MOD : S_REQ;
                end
            end
            S_REQ: begin
                pend_valid_next = 1'b1;
                pend_tag_next   = in_tag_reg;
                pend_pri_next   = in_pri_reg;
                pend_bytes_next = in_bytes_reg;
                priority if (in_bytes_reg > refill_reg) begin
                    pend_outcome_next = OUT_TOO_LARGE;
                end else if (credit_reg >= in_bytes_reg) begin
                    credit_next       = credit_reg - in_bytes_reg;
                    pend_outcome_next = OUT_GRANTED;
                end else if (count_reg[in_pri_reg] >= CW'(QD)) begin
                    pend_outcome_next = OUT_FULL;
                end else begin
                    wr_push_en  = 1'b1;
                    wr_rem_en   = 1'b1;
                    wr_rem_data = in_bytes_reg;
                    wr_addr     = in_pri_reg ? HIGH_BASE + AW'(tail_idx) : AW'(tail_idx);
                    count_next[in_pri_reg] = count_reg[in_pri_reg] + CW'(1);
                    pend_outcome_next = OUT_QUEUED;
                end
                state_next = S_FLUSH;
            end
            S_MOD: begin
                if (mod_status.done) begin
                    q_next      = (mod_status.remainder != '0);
                    phase_next  = 1'b0;
                    credit_next = refill_reg;
                    state_next  = S_RD;
                end
            end
            S_RD: begin
                if (count_reg[q_reg] == '0) begin
                    if (!phase_reg) begin
                        q_next     = !q_reg;
                        phase_next = 1'b1;
                    end else begin
                        state_next = S_FLUSH;
                    end
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (credit_reg < rd_rem_reg) begin
                    wr_rem_en   = 1'b1;
                    credit_next = '0;
                    if (!phase_reg) begin
                        q_next     = !q_reg;
                        phase_next = 1'b1;
                        state_next = S_RD;
                    end else begin
                        state_next = S_FLUSH;
                    end
                end else if (!pend_valid_reg || out_free) begin
                    credit_next = credit_reg - rd_rem_reg;
                    if (head_reg[q_reg] == HW'(QD - 1)) begin
                        head_next[q_reg] = '0;
                    end else begin
                        head_next[q_reg] = head_reg[q_reg] + HW'(1);
                    end
                    count_next[q_reg] = count_reg[q_reg] - CW'(1);
                    m_load            = pend_valid_reg;
                    pend_valid_next   = 1'b1;
                    pend_outcome_next = OUT_FROM_Q;
                    pend_tag_next     = rd_tag_reg;
                    pend_pri_next     = q_reg;
                    pend_bytes_next   = rd_orig_reg;
                    state_next        = S_RD;
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_load          = 1'b1;
                    m_load_last     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            refill_reg     <= BW'(1048576);
            fair_reg       <= FAIR_W'(10);
            credit_reg     <= '0;
            head_reg[0]    <= '0;
            head_reg[1]    <= '0;
            count_reg[0]   <= '0;
            count_reg[1]   <= '0;
            q_reg          <= 1'b0;
            phase_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            refill_reg     <= refill_next;
            fair_reg       <= fair_next;
            credit_reg     <= credit_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            q_reg          <= q_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_outcome_reg <= pend_outcome_next;
        pend_tag_reg     <= pend_tag_next;
        pend_pri_reg     <= pend_pri_next;
        pend_bytes_reg   <= pend_bytes_next;
        if (accept) begin
            in_bytes_reg <= BW'(s_byte_count);
            in_pri_reg   <= s_priority_req;
            in_tag_reg   <= s_request_tag;
        end
        if (m_load) begin
            m_outcome_reg <= pend_outcome_reg;
            m_tag_reg     <= pend_tag_reg;
            m_pri_reg     <= pend_pri_reg;
            m_bytes_reg   <= FIELD_W'(pend_bytes_reg);
            m_last_reg    <= m_load_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_rem_en) begin
            mem_rem[wr_addr] <= wr_rem_data;
        end
        if (wr_push_en) begin
            mem_orig[wr_addr] <= in_bytes_reg;
            mem_tag[wr_addr]  <= in_tag_reg;
        end
        rd_rem_reg  <= mem_rem[rd_addr];
        rd_orig_reg <= mem_orig[rd_addr];
        rd_tag_reg  <= mem_tag[rd_addr];
    end

    assign m_valid          = m_valid_reg;
    assign m_outcome        = m_outcome_reg;
    assign m_grant_tag      = m_tag_reg;
    assign m_grant_priority = m_pri_reg;
    assign m_grant_bytes    = m_bytes_reg;
    assign m_last_result    = m_last_reg;

endmodule

/* hdl/tpg_mod_unit.sv */
// Bit-serial remainder unit that reduces the tick's random word modulo the fairness value.
module tpg_mod_unit
    import tpg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RND_W-1:0]  dividend,
    input  logic [FAIR_W-1:0] divisor,
    output mod_status_t       status
);

    localparam int CNT_W = $clog2(RND_W + 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [RND_W-1:0]  shift_reg, shift_next;
    logic [FAIR_W:0]   rem_reg,   rem_next;
    logic [FAIR_W-1:0] div_reg,   div_next;
    logic [FAIR_W:0]   trial;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        trial      = {rem_reg[FAIR_W-1:0], shift_reg[RND_W-1]};
        if (start) begin
            busy_next  = 1'b1;
            count_next = CNT_W'(RND_W);
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end else if (busy_reg) begin
            shift_next = {shift_reg[RND_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial - {1'b0, div_reg};
            end else begin
                rem_next = trial;
            end
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign status.done      = done_reg;
    assign status.remainder = rem_reg[FAIR_W-1:0];

endmodule

/* hdl/tpg_checker.sv */
// Port-level assertions for the granter and the bind that attaches them.
module tpg_checker
    import tpg_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [OUTCOME_W-1:0] m_outcome,
    input logic [TAG_W-1:0]     m_grant_tag,
    input logic                 m_last_result
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_outcome) && $stable(m_grant_tag))
        else $error("A stalled result transfer changed.");

    a_busy_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted again before the previous item was worked.");

    a_outcome_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_outcome <= OUT_FROM_Q)
        else $error("Result carries an undefined outcome code.");

    a_request_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome != OUT_FROM_Q |-> m_last_result)
        else $error("A request result is not marked as the last.");

endmodule

bind two_priority_token_bucket_granter tpg_checker u_tpg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_outcome     (m_outcome),
    .m_grant_tag   (m_grant_tag),
    .m_last_result (m_last_result)
);

/* dv/two_priority_token_bucket_granter_tb.sv */
// Self-checking testbench for the two-priority token bucket granter.
`timescale 1ns / 100ps

module two_priority_token_bucket_granter_tb
    import tpg_pkg::*;
;

    localparam int DEPTH = 16;
    localparam int WDOG_LIMIT = 20000;
    localparam int EXP_SIZE = 256;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [TAG_W-1:0]     tag;
        logic                 pri;
        logic [FIELD_W-1:0]   bytes;
        logic                 last;
    } grant_t;

    typedef struct {
        logic               op;
        logic [FIELD_W-1:0] bytes;
        logic               pri;
        logic [TAG_W-1:0]   tag;
        logic [RND_W-1:0]   rnd;
        logic               fixed;
        logic [OUTCOME_W-1:0] want;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_operation;
    logic [FIELD_W-1:0]   s_byte_count;
    logic                 s_priority_req;
    logic [TAG_W-1:0]     s_request_tag;
    logic [RND_W-1:0]     s_random_word;
    logic                 m_valid;
    logic                 m_ready;
    logic [OUTCOME_W-1:0] m_outcome;
    logic [TAG_W-1:0]     m_grant_tag;
    logic                 m_grant_priority;
    logic [FIELD_W-1:0]   m_grant_bytes;
    logic                 m_last_result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;

    two_priority_token_bucket_granter dut (.*);

    // Predictor state.
    logic [FIELD_W-1:0] p_refill;
    logic [FAIR_W-1:0]  p_fair;
    logic [FIELD_W-1:0] p_credit;
    logic [FIELD_W-1:0] q_rem  [2][DEPTH];
    logic [FIELD_W-1:0] q_orig [2][DEPTH];
    logic [TAG_W-1:0]   q_tag  [2][DEPTH];
    int                 q_head [2];
    int                 q_cnt  [2];

    grant_t exp_fifo [EXP_SIZE];
    int     exp_wr = 0;
    int     exp_rd = 0;
    int     errors = 0;
    int     idle_cycles = 0;
    bit     calm = 0;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int exp_level();
        return exp_wr - exp_rd;
    endfunction

    function automatic void exp_put(input grant_t g);
        exp_fifo[exp_wr % EXP_SIZE] = g;
        exp_wr++;
    endfunction

    function automatic void serve_queue(input int q);
        int s;
        while (q_cnt[q] != 0) begin
            s = q_head[q];
            if (p_credit < q_rem[q][s]) begin
                q_rem[q][s] = q_rem[q][s] - p_credit;
                p_credit = '0;
                break;
            end
            p_credit -= q_rem[q][s];
            exp_put('{OUT_FROM_Q, q_tag[q][s], q[0], q_orig[q][s], 1'b0});
            q_head[q] = (q_head[q] + 1) % DEPTH;
            q_cnt[q]--;
        end
    endfunction

    function automatic logic [OUTCOME_W-1:0] predict_grants(input row_t it);
        logic [OUTCOME_W-1:0] code;
        int f, first, n, s;
        if (!it.op) begin
            if (it.bytes > p_refill) code = OUT_TOO_LARGE;
            else if (p_credit >= it.bytes) begin
                p_credit -= it.bytes;
                code = OUT_GRANTED;
            end else if (q_cnt[it.pri] >= DEPTH) code = OUT_FULL;
            else begin
                s = (q_head[it.pri] + q_cnt[it.pri]) % DEPTH;
                q_rem[it.pri][s] = it.bytes;
                q_orig[it.pri][s] = it.bytes;
                q_tag[it.pri][s] = it.tag;
                q_cnt[it.pri]++;
                code = OUT_QUEUED;
            end
            exp_put('{code, it.tag, it.pri, it.bytes, 1'b1});
            return code;
        end
        f = int'(p_fair);
        if (f == 0) f = 1;
        if (f > int'(FAIR_LIMIT)) f = int'(FAIR_LIMIT);
        first = (int'(it.rnd) % f == 0) ? 0 : 1;
        p_credit = p_refill;
        n = exp_wr;
        serve_queue(first);
        serve_queue(first ^ 1);
        if (exp_wr > n)
            exp_fifo[(exp_wr - 1) % EXP_SIZE].last = 1'b1;
        return OUT_GRANTED;
    endfunction

    always @(posedge aclk) begin
        grant_t w;
        if (aresetn && m_valid && m_ready) begin
            if (exp_level() == 0) begin
                report("unexpected result", 64'(m_grant_tag), 64'd0);
            end else begin
                w = exp_fifo[exp_rd % EXP_SIZE];
                exp_rd++;
                if (m_outcome !== w.outcome)
                    report("outcome", 64'(m_outcome), 64'(w.outcome));
                if (m_grant_tag !== w.tag)
                    report("tag", 64'(m_grant_tag), 64'(w.tag));
                if (m_grant_priority !== w.pri)
                    report("priority", 64'(m_grant_priority), 64'(w.pri));
                if (m_grant_bytes !== w.bytes)
                    report("bytes", 64'(m_grant_bytes), 64'(w.bytes));
                if (m_last_result !== w.last)
                    report("last", 64'(m_last_result), 64'(w.last));
            end
        end
    end

    // Receiver stalls in random bursts.
    always @(posedge aclk) begin
        int gap;
        if (!aresetn || calm) begin
            m_ready <= 1'b1;
        end else if (gap > 0) begin
            gap--;
            m_ready <= (gap == 0);
        end else if ($urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_REFILL) p_refill = val;
        else if (idx == CFG_FAIRNESS) p_fair = val[FAIR_W-1:0];
        @(posedge aclk);
    endtask

    task automatic drain_and_settle();
        while (exp_level() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic send_item(input row_t it);
        logic [OUTCOME_W-1:0] code;
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= it.op;
        s_byte_count   <= it.bytes;
        s_priority_req <= it.pri;
        s_request_tag  <= it.tag;
        s_random_word  <= it.rnd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        code = predict_grants(it);
        if (it.fixed && code !== it.want) report("directed outcome", 64'(code), 64'(it.want));
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic row_t req(input logic [FIELD_W-1:0] b, input logic p,
                                 input logic [TAG_W-1:0] t);
        return '{1'b0, b, p, t, '0, 1'b0, OUT_GRANTED};
    endfunction

    function automatic row_t tick(input logic [RND_W-1:0] r);
        return '{1'b1, '0, 1'b0, '0, r, 1'b0, OUT_GRANTED};
    endfunction

    function automatic row_t fixed_req(input logic [FIELD_W-1:0] b, input logic p,
                                       input logic [TAG_W-1:0] t,
                                       input logic [OUTCOME_W-1:0] w);
        return '{1'b0, b, p, t, '0, 1'b1, w};
    endfunction

    initial begin
        row_t table_rows [13];
        row_t it;
        int phase, k, n;
        aresetn = 0;
        s_valid = 0; s_operation = 0; s_byte_count = 0; s_priority_req = 0;
        s_request_tag = 0; s_random_word = 0;
        cfg_valid = 0; cfg_index = CFG_REFILL; cfg_data = 0;
        p_refill = 32'd1048576; p_fair = 7'd10; p_credit = 0;
        q_head = '{0, 0}; q_cnt = '{0, 0};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part, default registers: no credit after reset.
        table_rows[0]  = fixed_req(32'd0, 1'b0, 16'h0000, OUT_GRANTED);
        table_rows[1]  = fixed_req(32'hFFFF_FFFF, 1'b1, 16'hFFFF, OUT_TOO_LARGE);
        table_rows[2]  = fixed_req(32'd1048577, 1'b0, 16'h1234, OUT_TOO_LARGE);
        table_rows[3]  = fixed_req(32'd1048576, 1'b1, 16'hABCD, OUT_QUEUED);
        table_rows[4]  = fixed_req(32'd1, 1'b0, 16'h0001, OUT_QUEUED);
        table_rows[5]  = tick(16'd0);
        table_rows[6]  = tick(16'hFFFF);
        table_rows[7]  = req(32'd700000, 1'b1, 16'h0101);
        table_rows[8]  = req(32'd600000, 1'b1, 16'h0102);
        table_rows[9]  = req(32'd900000, 1'b0, 16'h0103);
        table_rows[10] = tick(16'd3);
        table_rows[11] = tick(16'd10);
        table_rows[12] = tick(16'd7);
        foreach (table_rows[i]) send_item(table_rows[i]);
        drain_and_settle();

        // Fill a queue to the brim with zero credit left.
        write_reg(CFG_REFILL, 32'd100);
        write_reg(CFG_FAIRNESS, 32'd1);
        send_item(tick(16'd5));
        send_item(req(32'd100, 1'b0, 16'h0200));
        for (k = 0; k < DEPTH; k++) send_item(req(32'd50, 1'b1, 16'(16'h0300 + k)));
        send_item(fixed_req(32'd1, 1'b1, 16'h03FF, OUT_FULL));
        send_item(tick(16'd9));
        // Let every result arrive before sending more.
        while (exp_level() != 0) @(posedge aclk);
        for (k = 0; k < 10; k++) send_item(tick(16'(k)));
        drain_and_settle();

        // Random phases across register settings, extremes among them.
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(CFG_REFILL, 32'd0); write_reg(CFG_FAIRNESS, 32'd0); end
                1: begin
                    write_reg(CFG_REFILL, 32'hFFFF_FFFF);
                    write_reg(CFG_FAIRNESS, 32'd127);
                end
                2: begin write_reg(CFG_REFILL, 32'd1000); write_reg(CFG_FAIRNESS, 32'd100); end
                3: begin write_reg(CFG_REFILL, 32'd4000); write_reg(CFG_FAIRNESS, 32'd3); end
                default: begin
                    write_reg(CFG_REFILL, 32'd2500);
                    write_reg(CFG_FAIRNESS, 32'($urandom_range(1, 100)));
                    calm = 1;
                end
            endcase
            n = (phase == 0) ? 10 : 18;
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 5) == 0) it = tick(16'($urandom));
                else begin
                    case ($urandom_range(0, 3))
                        0: it = req($urandom, 1'($urandom), 16'($urandom));
                        1: it = req(32'($urandom_range(0, 1)), 1'($urandom), 16'($urandom));
                        default: it = req(32'($urandom_range(0, p_refill > 3000 ? 3000
                                                             : p_refill)),
                                          1'($urandom), 16'($urandom));
                    endcase
                end
                send_item(it);
            end
            send_item(tick(16'($urandom)));
            send_item(tick(16'($urandom)));
            drain_and_settle();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/tpg_pkg.sv
hdl/tpg_mod_unit.sv
hdl/two_priority_token_bucket_granter.sv
hdl/tpg_checker.sv
dv/two_priority_token_bucket_granter_tb.sv
